// ===== rtl/msf_sector_address_unit_core_assert.svh =====
// Assertion macros used by the port checker of the sector address unit.
`ifndef MSF_SECTOR_ADDRESS_UNIT_CORE_ASSERT_SVH
`define MSF_SECTOR_ADDRESS_UNIT_CORE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define MSFA_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed: implication");

// Next-cycle implication, held off during reset.
`define MSFA_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/msfa_pkg.sv =====
`timescale 1ns / 1ps

package msfa_pkg;

   localparam int SECTORS_PER_SEC = 75;
   localparam int SECS_PER_MIN    = 60;

   localparam logic [23:0] RECIP_75       = 24'd14316558;
   localparam int          RECIP_75_SHIFT = 30;
   localparam logic [18:0] RECIP_60       = 19'd279621;
   localparam int          RECIP_60_SHIFT = 24;

   typedef enum logic [2:0] {
      CMD_TO_TOTAL   = 3'd0,
      CMD_FROM_TOTAL = 3'd1,
      CMD_ADD        = 3'd2,
      CMD_SUB        = 3'd3,
      CMD_INC        = 3'd4,
      CMD_CMP        = 3'd5
   } cmd_type;

   typedef struct packed {
      logic        msf_op;
      logic [20:0] total_out;
      logic        less;
      logic        equal;
   } flags_type;

   typedef struct packed {
      logic [23:0] total;
      flags_type   flags;
   } mid_type;

endpackage

// ===== rtl/msfa_req_if.sv =====
`timescale 1ns / 1ps

interface msfa_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic [7:0]  a_minutes;
   logic [5:0]  a_seconds;
   logic [6:0]  a_sectors;
   logic [7:0]  b_minutes;
   logic [5:0]  b_seconds;
   logic [6:0]  b_sectors;
   logic [23:0] total_in;

   modport source (
      output valid, command, a_minutes, a_seconds, a_sectors,
             b_minutes, b_seconds, b_sectors, total_in,
      input  ready
   );

   modport sink (
      input  valid, command, a_minutes, a_seconds, a_sectors,
             b_minutes, b_seconds, b_sectors, total_in,
      output ready
   );
endinterface

// ===== rtl/msfa_rsp_if.sv =====
`timescale 1ns / 1ps

interface msfa_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  r_minutes;
   logic [5:0]  r_seconds;
   logic [6:0]  r_sectors;
   logic [20:0] total_out;
   logic        less;
   logic        equal;
   logic        overflow;

   modport source (
      output valid, r_minutes, r_seconds, r_sectors, total_out, less, equal, overflow,
      input  ready
   );

   modport sink (
      input  valid, r_minutes, r_seconds, r_sectors, total_out, less, equal, overflow,
      output ready
   );
endinterface

// ===== rtl/msf_sector_address_unit_core.sv =====
`timescale 1ns / 1ps
// MSF sector address unit: arithmetic on minutes:seconds:sectors disc addresses.
// req_bus carries one request: a command, operands A and B, and a total count.
// rsp_bus returns exactly one result per request, in request order.
// Both channels use valid/ready; a transfer happens when both are high.
// Pipeline stages, in order from request to result: operand totals,
// command select, multiply by the reciprocal of 75, split into minutes and
// sectors, then seconds and the output register.
// One request per cycle while rsp_bus.ready is high; each stage has a valid bit.
// The two reciprocal multiplies (24 by 24 and 18 by 19 bits) set the stage depth.
// Stall: when rsp_bus.ready is low the result holds; upstream stages still fill
// their empty slots, and req_bus.ready falls only once every stage is full.
// Reset: synchronous, active high; clears all valid bits, so the pipeline is
// empty and req_bus.ready is high the cycle after reset drops.
// Codes 6 and 7 return a result with every field zero.
module msf_sector_address_unit_core (
   input logic        clock,
   input logic        reset,
   msfa_req_if.sink   req_bus,
   msfa_rsp_if.source rsp_bus
);
   import msfa_pkg::*;

   logic    mid_valid;
   logic    mid_ready;
   mid_type mid_data;

   msfa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .mid_valid (mid_valid),
      .mid_ready (mid_ready),
      .mid_data  (mid_data)
   );

   msfa_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .mid_valid (mid_valid),
      .mid_ready (mid_ready),
      .mid_data  (mid_data),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ===== rtl/msfa_front.sv =====
`timescale 1ns / 1ps

module msfa_front (
   input  logic             clock,
   input  logic             reset,
   msfa_req_if.sink         req_bus,
   output logic             mid_valid,
   input  logic             mid_ready,
   output msfa_pkg::mid_type mid_data
);
   import msfa_pkg::*;

   typedef struct packed {
      logic [2:0]  command;
      logic [20:0] total_a;
      logic [20:0] total_b;
      logic [23:0] total_in;
      logic        equal;
   } s1_type;

   function automatic logic [20:0] msf_total(logic [7:0] m, logic [5:0] s, logic [6:0] f);
      logic [13:0] secs;
      secs = 14'(m) * 14'(SECS_PER_MIN) + 14'(s);
      return 21'(secs) * 21'(SECTORS_PER_SEC) + 21'(f);
   endfunction

   s1_type  s1_ff, s1_in;
   mid_type s2_ff, s2_in;
   logic    s1_valid_ff, s2_valid_ff;
   logic    s1_load, s2_load;

   assign s2_load       = !s2_valid_ff || mid_ready;
   assign s1_load       = !s1_valid_ff || s2_load;
   assign req_bus.ready = s1_load;
   assign mid_valid     = s2_valid_ff;
   assign mid_data      = s2_ff;

   always_comb begin
      s1_in.command  = req_bus.command;
      s1_in.total_a  = msf_total(req_bus.a_minutes, req_bus.a_seconds, req_bus.a_sectors);
      s1_in.total_b  = msf_total(req_bus.b_minutes, req_bus.b_seconds, req_bus.b_sectors);
      s1_in.total_in = req_bus.total_in;
      s1_in.equal    = (req_bus.a_minutes == req_bus.b_minutes) &&
                       (req_bus.a_seconds == req_bus.b_seconds) &&
                       (req_bus.a_sectors == req_bus.b_sectors);
   end

   always_comb begin
      s2_in = '0;
      case (s1_ff.command)
         CMD_TO_TOTAL: begin
            s2_in.flags.total_out = s1_ff.total_a;
         end
         CMD_FROM_TOTAL: begin
            s2_in.total        = s1_ff.total_in;
            s2_in.flags.msf_op = 1'b1;
         end
         CMD_ADD: begin
            s2_in.total        = 24'(s1_ff.total_a) + 24'(s1_ff.total_b);
            s2_in.flags.msf_op = 1'b1;
         end
         CMD_SUB: begin
            if (s1_ff.total_a >= s1_ff.total_b) begin
               s2_in.total = 24'(s1_ff.total_a - s1_ff.total_b);
            end
            s2_in.flags.msf_op = 1'b1;
         end
         CMD_INC: begin
            s2_in.total        = 24'(s1_ff.total_a) + 24'd1;
            s2_in.flags.msf_op = 1'b1;
         end
         CMD_CMP: begin
            s2_in.flags.less  = s1_ff.total_a < s1_ff.total_b;
            s2_in.flags.equal = s1_ff.equal;
         end
         default: begin
            s2_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (s2_load) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_ff <= s1_in;
      end
      if (s2_load) begin
         s2_ff <= s2_in;
      end
   end

endmodule

// ===== rtl/msfa_divider.sv =====
`timescale 1ns / 1ps

module msfa_divider (
   input  logic              clock,
   input  logic              reset,
   input  logic              mid_valid,
   output logic              mid_ready,
   input  msfa_pkg::mid_type mid_data,
   msfa_rsp_if.source        rsp_bus
);
   import msfa_pkg::*;

   typedef struct packed {
      logic [23:0] total;
      logic [17:0] quot;
      flags_type   flags;
   } s3_type;

   typedef struct packed {
      logic [17:0] quot;
      logic [11:0] mins;
      logic [6:0]  sectors;
      flags_type   flags;
   } s4_type;

   typedef struct packed {
      logic [7:0]  r_minutes;
      logic [5:0]  r_seconds;
      logic [6:0]  r_sectors;
      logic [20:0] total_out;
      logic        less;
      logic        equal;
      logic        overflow;
   } s5_type;

   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   logic   s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic   s3_load, s4_load, s5_load;

   logic [47:0] prod75;
   logic [36:0] prod60;
   logic [23:0] sect_full;
   logic [17:0] sec_full;

   assign s5_load   = !s5_valid_ff || rsp_bus.ready;
   assign s4_load   = !s4_valid_ff || s5_load;
   assign s3_load   = !s3_valid_ff || s4_load;
   assign mid_ready = s3_load;

   always_comb begin
      prod75      = 48'(mid_data.total) * 48'(RECIP_75);
      s3_in.total = mid_data.total;
      s3_in.quot  = prod75[RECIP_75_SHIFT+17:RECIP_75_SHIFT];
      s3_in.flags = mid_data.flags;
   end

   always_comb begin
      prod60        = 37'(s3_ff.quot) * 37'(RECIP_60);
      sect_full     = s3_ff.total - 24'(s3_ff.quot) * 24'(SECTORS_PER_SEC);
      s4_in.quot    = s3_ff.quot;
      s4_in.mins    = prod60[RECIP_60_SHIFT+11:RECIP_60_SHIFT];
      s4_in.sectors = sect_full[6:0];
      s4_in.flags   = s3_ff.flags;
   end

   always_comb begin
      sec_full        = s4_ff.quot - 18'(s4_ff.mins) * 18'(SECS_PER_MIN);
      s5_in           = '0;
      s5_in.total_out = s4_ff.flags.total_out;
      s5_in.less      = s4_ff.flags.less;
      s5_in.equal     = s4_ff.flags.equal;
      if (s4_ff.flags.msf_op) begin
         s5_in.r_minutes = s4_ff.mins[7:0];
         s5_in.r_seconds = sec_full[5:0];
         s5_in.r_sectors = s4_ff.sectors;
         s5_in.overflow  = |s4_ff.mins[11:8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (s3_load) begin
            s3_valid_ff <= mid_valid;
         end
         if (s4_load) begin
            s4_valid_ff <= s3_valid_ff;
         end
         if (s5_load) begin
            s5_valid_ff <= s4_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_load) begin
         s3_ff <= s3_in;
      end
      if (s4_load) begin
         s4_ff <= s4_in;
      end
      if (s5_load) begin
         s5_ff <= s5_in;
      end
   end

   assign rsp_bus.valid     = s5_valid_ff;
   assign rsp_bus.r_minutes = s5_ff.r_minutes;
   assign rsp_bus.r_seconds = s5_ff.r_seconds;
   assign rsp_bus.r_sectors = s5_ff.r_sectors;
   assign rsp_bus.total_out = s5_ff.total_out;
   assign rsp_bus.less      = s5_ff.less;
   assign rsp_bus.equal     = s5_ff.equal;
   assign rsp_bus.overflow  = s5_ff.overflow;

endmodule

// ===== rtl/msfa_port_checker.sv =====
`timescale 1ns / 1ps
`include "msf_sector_address_unit_core_assert.svh"

module msfa_port_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  r_minutes,
   input logic [5:0]  r_seconds,
   input logic [6:0]  r_sectors,
   input logic [20:0] total_out,
   input logic        less,
   input logic        equal,
   input logic        overflow
);

   `MSFA_ASSERT_NEXT(rsp_valid_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `MSFA_ASSERT_NEXT(rsp_data_hold, clock, reset, rsp_valid && !rsp_ready, $stable({r_minutes, r_seconds, r_sectors, total_out, less, equal, overflow}))
   `MSFA_ASSERT_IMPLY(empty_accepts, clock, reset, !rsp_valid, req_ready)
   `MSFA_ASSERT_IMPLY(msf_normalized, clock, reset, rsp_valid, (r_seconds < 6'd60) && (r_sectors < 7'd75))
   `MSFA_ASSERT_IMPLY(compare_clean, clock, reset, rsp_valid && (less || equal), (r_minutes == 8'd0) && (r_seconds == 6'd0) && (r_sectors == 7'd0) && (total_out == 21'd0) && !overflow)

endmodule

bind msf_sector_address_unit_core msfa_port_checker u_port_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .r_minutes (rsp_bus.r_minutes),
   .r_seconds (rsp_bus.r_seconds),
   .r_sectors (rsp_bus.r_sectors),
   .total_out (rsp_bus.total_out),
   .less      (rsp_bus.less),
   .equal     (rsp_bus.equal),
   .overflow  (rsp_bus.overflow)
);

// ===== tb/sv/msf_sector_address_unit_core_tb.sv =====
`timescale 1ns / 1ps

module msf_sector_address_unit_core_tb;
   import msfa_pkg::*;

   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;
   localparam int         RANDOM_REQUESTS = 1500;
   localparam int         LONG_HOLD_AT = 500;
   localparam int         LONG_HOLD_CYCLES = 150;

   typedef struct packed {
      logic [2:0]  command;
      logic [7:0]  a_minutes;
      logic [5:0]  a_seconds;
      logic [6:0]  a_sectors;
      logic [7:0]  b_minutes;
      logic [5:0]  b_seconds;
      logic [6:0]  b_sectors;
      logic [23:0] total_in;
   } msf_request_type;

   typedef struct packed {
      logic [7:0]  r_minutes;
      logic [5:0]  r_seconds;
      logic [6:0]  r_sectors;
      logic [20:0] total_out;
      logic        less;
      logic        equal;
      logic        overflow;
   } msf_result_type;

   typedef struct {
      msf_request_type request;
      bit              typed;
      msf_result_type  result;
   } stim_row_type;

   logic clock;
   logic reset;

   msfa_req_if req_ch ();
   msfa_rsp_if rsp_ch ();

   msf_sector_address_unit_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   msf_result_type pending_results[$];
   stim_row_type   directed_rows[$];
   int             fail_count = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned sector_total(input logic [7:0] m, input logic [5:0] s,
                                                input logic [6:0] f);
      return (int'(m) * SECS_PER_MIN + int'(s)) * SECTORS_PER_SEC + int'(f);
   endfunction

   function automatic msf_result_type predict_result(input msf_request_type r);
      msf_result_type p;
      int unsigned ta;
      int unsigned tb;
      int unsigned t;
      int unsigned secs;
      int unsigned mins;
      bit          to_msf;
      p = '0;
      t = 0;
      to_msf = 1'b0;
      ta = sector_total(r.a_minutes, r.a_seconds, r.a_sectors);
      tb = sector_total(r.b_minutes, r.b_seconds, r.b_sectors);
      case (r.command)
         CMD_TO_TOTAL: p.total_out = ta[20:0];
         CMD_FROM_TOTAL: begin
            t = {8'd0, r.total_in};
            to_msf = 1'b1;
         end
         CMD_ADD: begin
            t = ta + tb;
            to_msf = 1'b1;
         end
         CMD_SUB: begin
            t = (tb > ta) ? 0 : ta - tb;
            to_msf = 1'b1;
         end
         CMD_INC: begin
            t = ta + 1;
            to_msf = 1'b1;
         end
         CMD_CMP: begin
            p.less  = ta < tb;
            p.equal = r.a_minutes == r.b_minutes && r.a_seconds == r.b_seconds &&
                      r.a_sectors == r.b_sectors;
         end
         default: ;
      endcase
      if (to_msf) begin
         secs = t / SECTORS_PER_SEC;
         mins = secs / SECS_PER_MIN;
         p.r_minutes = mins[7:0];
         p.r_seconds = 6'(secs % SECS_PER_MIN);
         p.r_sectors = 7'(t % SECTORS_PER_SEC);
         p.overflow  = mins > 255;
      end
      return p;
   endfunction

   function automatic msf_request_type mk_request(input logic [2:0] cmd,
                                                  input logic [7:0] am, input logic [5:0] as,
                                                  input logic [6:0] af, input logic [7:0] bm,
                                                  input logic [5:0] bs, input logic [6:0] bf,
                                                  input logic [23:0] tin);
      msf_request_type r;
      r = '{cmd, am, as, af, bm, bs, bf, tin};
      return r;
   endfunction

   function automatic msf_result_type mk_result(input logic [7:0] m, input logic [5:0] s,
                                                input logic [6:0] f, input logic [20:0] tot,
                                                input logic lt, input logic eq,
                                                input logic ovf);
      msf_result_type p;
      p = '{m, s, f, tot, lt, eq, ovf};
      return p;
   endfunction

   task automatic random_address(output logic [7:0] m, output logic [5:0] s,
                                 output logic [6:0] f);
      int k;
      k = $urandom_range(0, 9);
      if (k < 2)
         m = 8'($urandom_range(250, 255));
      else if (k < 4)
         m = 8'($urandom_range(0, 3));
      else
         m = 8'($urandom_range(0, 255));
      s = (k == 9) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 59));
      f = (k >= 8) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 74));
   endtask

   task automatic random_request(output msf_request_type r);
      int k;
      k = $urandom_range(0, 99);
      if (k < 2)
         r.command = CMD_SPARE_6;
      else if (k < 4)
         r.command = CMD_SPARE_7;
      else
         r.command = 3'($urandom_range(CMD_TO_TOTAL, CMD_CMP));
      random_address(r.a_minutes, r.a_seconds, r.a_sectors);
      random_address(r.b_minutes, r.b_seconds, r.b_sectors);
      k = $urandom_range(0, 9);
      if (k < 4)
         r.total_in = 24'($urandom_range(0, 1151999));
      else if (k == 4)
         r.total_in = 24'($urandom_range(1151990, 1152010));
      else if (k < 7)
         r.total_in = 24'($urandom());
      else
         r.total_in = 24'($urandom_range(0, 9999));
      k = $urandom_range(0, 3);
      if ((r.command == CMD_CMP || r.command == CMD_SUB) && k == 0) begin
         r.b_minutes = r.a_minutes;
         r.b_seconds = r.a_seconds;
         r.b_sectors = r.a_sectors;
      end else if (r.command == CMD_SUB && k == 1) begin
         r.b_minutes = r.a_minutes;
      end
   endtask

   task automatic send_request(input msf_request_type r, input msf_result_type expected_result,
                               input bit burst);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.command   <= r.command;
      req_ch.a_minutes <= r.a_minutes;
      req_ch.a_seconds <= r.a_seconds;
      req_ch.a_sectors <= r.a_sectors;
      req_ch.b_minutes <= r.b_minutes;
      req_ch.b_seconds <= r.b_seconds;
      req_ch.b_sectors <= r.b_sectors;
      req_ch.total_in  <= r.total_in;
      do @(posedge clock); while (!req_ch.ready);
      pending_results.push_back(expected_result);
   endtask

   task automatic check_field(input string name, input logic [23:0] expv,
                              input logic [23:0] actv);
      if (actv !== expv) begin
         $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      msf_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            $error("result with no request outstanding");
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("r_minutes", 24'(want.r_minutes), 24'(rsp_ch.r_minutes));
            check_field("r_seconds", 24'(want.r_seconds), 24'(rsp_ch.r_seconds));
            check_field("r_sectors", 24'(want.r_sectors), 24'(rsp_ch.r_sectors));
            check_field("total_out", 24'(want.total_out), 24'(rsp_ch.total_out));
            check_field("less", 24'(want.less), 24'(rsp_ch.less));
            check_field("equal", 24'(want.equal), 24'(rsp_ch.equal));
            check_field("overflow", 24'(want.overflow), 24'(rsp_ch.overflow));
         end
      end
   end

   initial begin
      int taken;
      int stall;
      taken = 0;
      rsp_ch.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = ((taken / 170) % 3 == 2) ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         taken++;
         if (taken == LONG_HOLD_AT) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end
      end
   end

   initial begin
      #5000000;
      $display("msf_sector_address_unit_core_tb: FAIL");
      $finish;
   end

   initial begin
      msf_request_type r;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.command   <= CMD_TO_TOTAL;
      req_ch.a_minutes <= '0;
      req_ch.a_seconds <= '0;
      req_ch.a_sectors <= '0;
      req_ch.b_minutes <= '0;
      req_ch.b_seconds <= '0;
      req_ch.b_sectors <= '0;
      req_ch.total_in  <= '0;

      directed_rows.push_back('{mk_request(CMD_TO_TOTAL, 0, 0, 0, 9, 9, 9, 24'hFFFFFF), 1,
                                mk_result(0, 0, 0, 0, 0, 0, 0)});
      directed_rows.push_back('{mk_request(CMD_TO_TOTAL, 255, 59, 74, 0, 0, 0, 0), 1,
                                mk_result(0, 0, 0, 1151999, 0, 0, 0)});
      directed_rows.push_back('{mk_request(CMD_TO_TOTAL, 255, 63, 127, 0, 0, 0, 0), 1,
                                mk_result(0, 0, 0, 1152352, 0, 0, 0)});
      directed_rows.push_back('{mk_request(CMD_TO_TOTAL, 1, 2, 3, 4, 5, 6, 7), 0, '0});
      directed_rows.push_back('{mk_request(CMD_FROM_TOTAL, 0, 0, 0, 0, 0, 0, 0), 1,
                                mk_result(0, 0, 0, 0, 0, 0, 0)});
      directed_rows.push_back('{mk_request(CMD_FROM_TOTAL, 0, 0, 0, 0, 0, 0, 1151999), 1,
                                mk_result(255, 59, 74, 0, 0, 0, 0)});
      directed_rows.push_back('{mk_request(CMD_FROM_TOTAL, 0, 0, 0, 0, 0, 0, 1152000), 1,
                                mk_result(0, 0, 0, 0, 0, 0, 1)});
      directed_rows.push_back('{mk_request(CMD_FROM_TOTAL, 255, 63, 127, 255, 63, 127,
                                           24'hFFFFFF), 0, '0});
      directed_rows.push_back('{mk_request(CMD_ADD, 255, 59, 74, 0, 0, 1, 0), 1,
                                mk_result(0, 0, 0, 0, 0, 0, 1)});
      directed_rows.push_back('{mk_request(CMD_ADD, 0, 0, 74, 0, 0, 1, 0), 1,
                                mk_result(0, 1, 0, 0, 0, 0, 0)});
      directed_rows.push_back('{mk_request(CMD_ADD, 255, 63, 127, 255, 63, 127, 0), 0, '0});
      directed_rows.push_back('{mk_request(CMD_SUB, 0, 0, 0, 0, 0, 1, 0), 1,
                                mk_result(0, 0, 0, 0, 0, 0, 0)});
      directed_rows.push_back('{mk_request(CMD_SUB, 10, 0, 0, 10, 0, 0, 0), 1,
                                mk_result(0, 0, 0, 0, 0, 0, 0)});
      directed_rows.push_back('{mk_request(CMD_SUB, 1, 0, 0, 0, 0, 1, 0), 1,
                                mk_result(0, 59, 74, 0, 0, 0, 0)});
      directed_rows.push_back('{mk_request(CMD_SUB, 255, 63, 127, 0, 0, 0, 0), 0, '0});
      directed_rows.push_back('{mk_request(CMD_INC, 0, 59, 74, 0, 0, 0, 0), 1,
                                mk_result(1, 0, 0, 0, 0, 0, 0)});
      directed_rows.push_back('{mk_request(CMD_INC, 255, 59, 74, 0, 0, 0, 0), 1,
                                mk_result(0, 0, 0, 0, 0, 0, 1)});
      directed_rows.push_back('{mk_request(CMD_INC, 0, 0, 127, 0, 0, 0, 0), 1,
                                mk_result(0, 1, 53, 0, 0, 0, 0)});
      directed_rows.push_back('{mk_request(CMD_CMP, 12, 34, 56, 12, 34, 56, 0), 1,
                                mk_result(0, 0, 0, 0, 0, 1, 0)});
      directed_rows.push_back('{mk_request(CMD_CMP, 0, 0, 0, 0, 0, 1, 0), 1,
                                mk_result(0, 0, 0, 0, 1, 0, 0)});
      directed_rows.push_back('{mk_request(CMD_CMP, 0, 1, 0, 0, 0, 75, 0), 1,
                                mk_result(0, 0, 0, 0, 0, 0, 0)});
      directed_rows.push_back('{mk_request(CMD_CMP, 255, 59, 74, 0, 0, 0, 0), 1,
                                mk_result(0, 0, 0, 0, 0, 0, 0)});
      directed_rows.push_back('{mk_request(CMD_SPARE_6, 200, 40, 70, 100, 20, 10, 123456), 1,
                                mk_result(0, 0, 0, 0, 0, 0, 0)});
      directed_rows.push_back('{mk_request(CMD_SPARE_7, 255, 63, 127, 255, 63, 127,
                                           24'hFFFFFF), 1, mk_result(0, 0, 0, 0, 0, 0, 0)});

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].request,
                      directed_rows[i].typed ? directed_rows[i].result
                                             : predict_result(directed_rows[i].request),
                      1'b0);

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         random_request(r);
         send_request(r, predict_result(r), (i / 150) % 3 == 1);
      end
      req_ch.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0)
         $display("msf_sector_address_unit_core_tb: PASS");
      else
         $display("msf_sector_address_unit_core_tb: FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/msfa_pkg.sv
rtl/msfa_req_if.sv
rtl/msfa_rsp_if.sv
rtl/msfa_front.sv
rtl/msfa_divider.sv
rtl/msf_sector_address_unit_core.sv
rtl/msfa_port_checker.sv
tb/sv/msf_sector_address_unit_core_tb.sv
